FILE: src/lpe_pkg.sv
package lpe_pkg;

  // field widths
  localparam int PointW = 16;
  localparam int DegW   = 5;
  localparam int StepW  = 4;

  // number format and degree limit
  localparam int FracBits  = 14;
  localparam int MaxDegree = 15;
  localparam int OneInt    = 1 << FracBits;

  // datapath widths
  localparam int MulW       = 22;
  localparam int ProdW      = 2 * MulW;
  localparam int XpW        = 17;
  localparam int AccW       = 21;
  localparam int MagW       = 21;
  localparam int RecipShift = 21;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XP,
    ST_A,
    ST_B,
    ST_NUM,
    ST_RECIP,
    ST_CHECK,
    ST_FIX,
    ST_DONE
  } lpe_state_e;

  typedef enum logic [2:0] {
    PH_HOLD,
    PH_XP,
    PH_A,
    PH_B,
    PH_NUM,
    PH_RECIP,
    PH_CHECK,
    PH_FIX
  } lpe_phase_e;

  typedef struct packed {
    logic       load_item;
    logic       load_out;
    lpe_phase_e phase;
  } lpe_cmd_t;

  typedef struct packed {
    logic iterate;
    logic last_step;
  } lpe_status_t;

  // floor(2^RecipShift / k) for the step indexes that occur
  function automatic logic [MagW-1:0] recip(logic [StepW-1:0] k);
    logic [MagW-1:0] r;
    unique case (k)
      4'd2:    r = 21'd1048576;
      4'd3:    r = 21'd699050;
      4'd4:    r = 21'd524288;
      4'd5:    r = 21'd419430;
      4'd6:    r = 21'd349525;
      4'd7:    r = 21'd299593;
      4'd8:    r = 21'd262144;
      4'd9:    r = 21'd233016;
      4'd10:   r = 21'd209715;
      4'd11:   r = 21'd190650;
      4'd12:   r = 21'd174762;
      4'd13:   r = 21'd161319;
      4'd14:   r = 21'd149796;
      4'd15:   r = 21'd139810;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/legendre_polynomial_evaluator_unit.sv
// Legendre polynomial evaluator. A request carries a point x in signed Q1.14
// (16384 is 1.0) and a signed degree n; the block answers with P_n(x) in the
// same format, saturated to [-1.0, +1.0]. Negative degrees give 0, degree 0
// gives 1.0, degree 1 gives x (saturated). Higher degrees run the three-term
// recurrence P_k = ((2k-1) * floor(x * P_{k-1} / 2^14) - (k-1) * P_{k-2}) / k
// for k = 2 .. n, the division truncating toward zero and every term clamped
// to +/-1.0 before reuse. One request is worked on at a time. Each recurrence
// step walks seven phases on a single shared 22x22 multiplier (x*P, the two
// weightings, a reciprocal multiply for the division by k and its one-step
// correction). The result sits in an output register, so the next request is
// taken while the previous result still waits to be collected.
module legendre_polynomial_evaluator_unit import lpe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // request channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [PointW-1:0] point_i,
  input  logic signed [DegW-1:0]   degree_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [PointW-1:0] value_o
);

  // command and status between sequencer and datapath
  lpe_cmd_t    cmd;
  lpe_status_t status;

  // sequencer: walks the seven phases of each recurrence step
  lpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: term registers, shared multiplier, divide-by-k and saturation
  lpe_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .point_i  (point_i),
    .degree_i (degree_i),
    .status_o (status),
    .value_o  (value_o)
  );

endmodule

FILE: src/lpe_ctrl.sv
module lpe_ctrl import lpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  lpe_status_t status_i,
  output lpe_cmd_t    cmd_o
);

  lpe_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '{load_item: 1'b0, load_out: 1'b0, phase: PH_HOLD};
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = status_i.iterate ? ST_XP : ST_DONE;
        end
      end
      ST_XP: begin
        cmd_o.phase = PH_XP;
        state_d = ST_A;
      end
      ST_A: begin
        cmd_o.phase = PH_A;
        state_d = ST_B;
      end
      ST_B: begin
        cmd_o.phase = PH_B;
        state_d = ST_NUM;
      end
      ST_NUM: begin
        cmd_o.phase = PH_NUM;
        state_d = ST_RECIP;
      end
      ST_RECIP: begin
        cmd_o.phase = PH_RECIP;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.phase = PH_CHECK;
        state_d = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.phase = PH_FIX;
        state_d = status_i.last_step ? ST_DONE : ST_XP;
      end
      ST_DONE: begin
        // hand over once the output register is free or being emptied
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/lpe_datapath.sv
module lpe_datapath import lpe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lpe_cmd_t                 cmd_i,
  input  logic signed [PointW-1:0] point_i,
  input  logic signed [DegW-1:0]   degree_i,
  output lpe_status_t              status_o,
  output logic signed [PointW-1:0] value_o
);

  logic signed [PointW-1:0] x_q;
  logic signed [PointW-1:0] older_q;
  logic signed [PointW-1:0] newer_q;
  logic signed [PointW-1:0] value_q;
  logic [StepW-1:0]         k_q;
  logic [StepW-1:0]         deg_q;
  logic signed [ProdW-1:0]  mul_q;
  logic signed [AccW-1:0]   a_q;
  logic [MagW-1:0]          mag_q;
  logic                     neg_q;
  logic [MagW-1:0]          q0_q;

  // shared multiplier
  logic signed [MulW-1:0]   op_a, op_b;
  logic signed [ProdW-1:0]  product;
  logic                     mul_en;

  logic [StepW-1:0]         deg_clamp;
  logic signed [PointW-1:0] x_sat;
  logic signed [PointW-1:0] first_term;
  logic signed [XpW-1:0]    xp;
  logic signed [AccW:0]     num;
  logic [MagW-1:0]          rem;
  logic [MagW-1:0]          q_fix;
  logic [PointW-1:0]        mag_sat;
  logic signed [PointW-1:0] term;

  always_comb begin
    if (int'(degree_i) > MaxDegree) begin
      deg_clamp = StepW'(MaxDegree);
    end else begin
      deg_clamp = degree_i[StepW-1:0];
    end
  end

  always_comb begin
    if (point_i > PointW'(OneInt)) begin
      x_sat = PointW'(OneInt);
    end else if (point_i < -PointW'(OneInt)) begin
      x_sat = -PointW'(OneInt);
    end else begin
      x_sat = point_i;
    end
  end

  // P_n for n below two, and P_1 as the seed of the recurrence
  always_comb begin
    priority if (degree_i[DegW-1]) begin
      first_term = '0;
    end else if (deg_clamp == '0) begin
      first_term = PointW'(OneInt);
    end else begin
      first_term = x_sat;
    end
  end

  assign status_o.iterate   = !degree_i[DegW-1] && (deg_clamp >= StepW'(2));
  assign status_o.last_step = (k_q == deg_q);

  // floor(x * P_{k-1} / 2^FracBits)
  assign xp = mul_q[FracBits+XpW-1:FracBits];

  always_comb begin
    mul_en = 1'b1;
    op_a   = '0;
    op_b   = '0;
    unique case (cmd_i.phase)
      PH_XP: begin
        op_a = MulW'(x_q);
        op_b = MulW'(newer_q);
      end
      PH_A: begin
        op_a = MulW'(xp);
        op_b = $signed({{(MulW-StepW-1){1'b0}}, k_q - StepW'(1), 1'b1});
      end
      PH_B: begin
        op_a = MulW'(older_q);
        op_b = $signed({{(MulW-StepW){1'b0}}, k_q - StepW'(1)});
      end
      PH_RECIP: begin
        op_a = $signed({1'b0, mag_q});
        op_b = $signed({1'b0, recip(k_q)});
      end
      PH_CHECK: begin
        op_a = $signed({1'b0, mul_q[RecipShift+MagW-1:RecipShift]});
        op_b = $signed({{(MulW-StepW){1'b0}}, k_q});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign product = op_a * op_b;

  assign num = (AccW+1)'(a_q) - (AccW+1)'($signed(mul_q[AccW-1:0]));

  // quotient estimate is at most one short
  assign rem   = mag_q - mul_q[MagW-1:0];
  assign q_fix = q0_q + MagW'(rem >= MagW'(k_q));
  assign mag_sat = (q_fix > MagW'(OneInt)) ? PointW'(OneInt) : q_fix[PointW-1:0];
  assign term    = neg_q ? $signed(PointW'(0) - mag_sat) : $signed(mag_sat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      newer_q <= '0;
      k_q     <= '0;
      deg_q   <= '0;
    end else begin
      if (cmd_i.load_item) begin
        older_q <= PointW'(OneInt);
        newer_q <= first_term;
        k_q     <= StepW'(2);
        deg_q   <= deg_clamp;
      end else if (cmd_i.phase == PH_FIX) begin
        older_q <= newer_q;
        newer_q <= term;
        if (!status_o.last_step) begin
          k_q <= k_q + StepW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      x_q <= point_i;
    end
    if (mul_en) begin
      mul_q <= product;
    end
    if (cmd_i.phase == PH_B) begin
      a_q <= mul_q[AccW-1:0];
    end
    if (cmd_i.phase == PH_NUM) begin
      neg_q <= num[AccW];
      mag_q <= num[AccW] ? MagW'(-num) : MagW'(num);
    end
    if (cmd_i.phase == PH_CHECK) begin
      q0_q <= mul_q[RecipShift+MagW-1:RecipShift];
    end
    if (cmd_i.load_out) begin
      value_q <= newer_q;
    end
  end

  assign value_o = value_q;

endmodule

FILE: tb/testbench.sv
module testbench;
  import lpe_pkg::*;

  localparam int IdleLimit  = 4000;  // cycles without any handshake before giving up
  localparam int SettleWait = 120;   // settle time before the final check

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic signed [PointW-1:0] point_i     = '0;
  logic signed [DegW-1:0]   degree_i    = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [PointW-1:0] value_o;

  // expected results, oldest first
  logic signed [PointW-1:0] value_queue[$];
  int error_count = 0;
  int idle_cycles = 0;

  // sender burst shaping
  int burst_left = 0;
  bit gaps_on    = 1'b1;
  // receiver stall shaping, written with nonblocking assignments
  logic stall_on = 1'b0;

  legendre_polynomial_evaluator_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .point_i     (point_i),
    .degree_i    (degree_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // clamp a term to +/-1.0
  function automatic longint clamp_unit(longint v);
    if (v > longint'(OneInt)) return longint'(OneInt);
    if (v < -longint'(OneInt)) return -longint'(OneInt);
    return v;
  endfunction

  // P_n(x) by the three-term recurrence, floored product, truncating division
  function automatic logic signed [PointW-1:0] legendre_value(
      logic signed [PointW-1:0] x_q, logic signed [DegW-1:0] n_q);
    longint x, deg, p_prev, p_cur, p_next, k;
    x = longint'(x_q);
    deg = longint'(n_q);
    if (deg > longint'(MaxDegree)) deg = longint'(MaxDegree);
    if (deg < 0) return '0;
    if (deg == 0) return PointW'(OneInt);
    p_prev = longint'(OneInt);
    p_cur  = clamp_unit(x);
    for (k = 2; k <= deg; k++) begin
      p_next = clamp_unit(((2 * k - 1) * ((x * p_cur) >>> FracBits) - (k - 1) * p_prev) / k);
      p_prev = p_cur;
      p_cur  = p_next;
    end
    return p_cur[PointW-1:0];
  endfunction

  // one request; valid stays high afterwards unless a gap follows
  task automatic send_request(logic signed [PointW-1:0] x, logic signed [DegW-1:0] n);
    in_valid_i <= 1'b1;
    point_i    <= x;
    degree_i   <= n;
    do @(posedge clk_i); while (in_stall_o);
    value_queue.push_back(legendre_value(x, n));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      if (gaps_on) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  // sender holds off until every outstanding result is back
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (value_queue.size() != 0) @(posedge clk_i);
  endtask

  // negative, zero and first degree, with point extremes
  task automatic test_trivial_degrees();
    send_request(16'sd1000, -5'sd16);
    send_request(-16'sd16384, -5'sd1);
    send_request(16'sd12345, 5'sd0);
    send_request(-16'sd32768, 5'sd0);
    send_request(16'sd16384, 5'sd1);
    send_request(-16'sd16384, 5'sd1);
    send_request(16'sd32767, 5'sd1);
    send_request(-16'sd32768, 5'sd1);
    send_request(16'sd0, 5'sd1);
    wait_all_results();
  endtask

  // recurrence at the top degree, at lower degrees and at out-of-range points
  task automatic test_recurrence_edges();
    send_request(16'sd16384, 5'sd15);
    send_request(-16'sd16384, 5'sd15);
    send_request(16'sd0, 5'sd15);
    send_request(16'sd32767, 5'sd15);
    send_request(-16'sd32768, 5'sd15);
    send_request(16'sd8192, 5'sd15);
    send_request(16'sd11585, 5'sd2);
    send_request(-16'sd5000, 5'sd3);
    send_request(16'sd1, 5'sd4);
    send_request(-16'sd16383, 5'sd7);
    send_request(16'sd20000, 5'sd10);
    send_request(16'sd16383, 5'sd14);
    wait_all_results();
  endtask

  task automatic test_random_requests(int count, bit with_gaps);
    logic signed [PointW-1:0] x;
    logic signed [DegW-1:0]   n;
    int pick;
    gaps_on = with_gaps;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) x = PointW'($urandom_range(0, 32768) - 16384);
      else if (pick < 95) x = PointW'($urandom_range(0, 65535));
      else begin
        case ($urandom_range(0, 4))
          0: x = 16'sd16384;
          1: x = -16'sd16384;
          2: x = 16'sd16383;
          3: x = -16'sd16383;
          default: x = '0;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) n = DegW'($urandom_range(2, 15));
      else if (pick < 90) n = DegW'($urandom_range(0, 1));
      else n = DegW'($urandom_range(16, 31));  // negative degrees
      send_request(x, n);
    end
  endtask

  // receiver: runs of stall and no-stall of random length
  always @(posedge clk_i) begin : stall_pattern
    int stall_run;
    if (stall_run <= 0) begin
      stall_run = $urandom_range(1, 24);
      out_stall_i <= stall_on && ($urandom_range(0, 2) == 0);
    end else begin
      stall_run--;
    end
  end

  // compare every collected value against the oldest expectation
  always @(posedge clk_i) begin : check_value
    logic signed [PointW-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (value_queue.size() == 0) begin
        $display("%0t: value %0d with no request outstanding", $time, value_o);
        error_count++;
      end else begin
        want = value_queue.pop_front();
        if (value_o !== want) begin
          $display("%0t: value mismatch, expected %0d, actual %0d", $time, want, value_o);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    stall_on <= 1'b1;
    test_trivial_degrees();
    test_recurrence_edges();
    // back to back, no stalls
    stall_on <= 1'b0;
    test_random_requests(280, 1'b0);
    stall_on <= 1'b1;
    test_random_requests(280, 1'b1);
    wait_all_results();
    test_random_requests(290, 1'b1);
    test_random_requests(280, 1'b0);
    wait_all_results();
    repeat (SettleWait) @(posedge clk_i);
    if (error_count == 0 && value_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
